// ===== design/rbs_pkg.sv =====
// Package for the ray/box slab test: number format, pipeline widths, beat types.
// No dependencies; every other design file but rbs_hit_if imports it.
package rbs_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int DIFF_W    = DATA_W + 1;
    localparam int NUM_W     = DIFF_W + FRAC_BITS;
    localparam int DEN_W     = DATA_W;
    localparam int REM_W     = DEN_W;
    localparam int NUM_AXES  = 3;
    localparam int ADDR_W    = 5;

    typedef logic signed [DATA_W-1:0] fix_t;

    localparam fix_t FIX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam fix_t FIX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [2:0] {
        REG_BOX_MIN_X = 3'd0,
        REG_BOX_MIN_Y = 3'd1,
        REG_BOX_MIN_Z = 3'd2,
        REG_BOX_MAX_X = 3'd3,
        REG_BOX_MAX_Y = 3'd4,
        REG_BOX_MAX_Z = 3'd5
    } reg_idx_t;

    // Per-axis side data that travels beside the dividers.
    typedef struct packed {
        logic dzero;
        logic dneg;
        logic in_slab;
        logic qneg_min;
        logic qneg_max;
    } axis_meta_t;

    typedef struct packed {
        axis_meta_t [NUM_AXES-1:0] ax;
        fix_t                      lo;
        fix_t                      hi;
    } meta_t;

    // Per-axis slab bounds, ready for narrowing.
    typedef struct packed {
        logic dzero;
        logic in_slab;
        fix_t t_entry;
        fix_t t_exit;
    } axis_t;

    typedef struct packed {
        logic                 alive;
        fix_t                 lo;
        fix_t                 hi;
        axis_t [NUM_AXES-1:0] ax;
    } merge_t;

endpackage

// ===== design/rbs_ray_if.sv =====
// Ray input channel: valid/ready handshake carrying one ray per beat.
// Depends on rbs_pkg for the fixed-point type.
interface rbs_ray_if;
    import rbs_pkg::*;

    logic valid;
    logic ready;
    fix_t origin_x;
    fix_t origin_y;
    fix_t origin_z;
    fix_t dir_x;
    fix_t dir_y;
    fix_t dir_z;
    fix_t t_start;
    fix_t t_end;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_start, t_end,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_start, t_end,
        output ready
    );
endinterface

// ===== design/rbs_hit_if.sv =====
// Result channel: valid/ready handshake carrying one hit bit per beat.
// No dependencies.
interface rbs_hit_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

// ===== design/rbs_cfg_regs.sv =====
// APB-style register file holding the six box corner coordinates.
// Depends on rbs_pkg.
module rbs_cfg_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rbs_pkg::ADDR_W-1:0] paddr,
    input  logic [rbs_pkg::DATA_W-1:0] pwdata,
    output logic [rbs_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output rbs_pkg::fix_t [2:0]        box_min,
    output rbs_pkg::fix_t [2:0]        box_max
);
    import rbs_pkg::*;

    fix_t [2:0] box_min_reg;
    fix_t [2:0] box_max_reg;
    reg_idx_t   idx;
    logic       wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_min_reg <= '0;
            box_max_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_BOX_MIN_X: box_min_reg[0] <= pwdata;
                REG_BOX_MIN_Y: box_min_reg[1] <= pwdata;
                REG_BOX_MIN_Z: box_min_reg[2] <= pwdata;
                REG_BOX_MAX_X: box_max_reg[0] <= pwdata;
                REG_BOX_MAX_Y: box_max_reg[1] <= pwdata;
                REG_BOX_MAX_Z: box_max_reg[2] <= pwdata;
                default: ; // drop writes past the last register
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_BOX_MIN_X: prdata = box_min_reg[0];
            REG_BOX_MIN_Y: prdata = box_min_reg[1];
            REG_BOX_MIN_Z: prdata = box_min_reg[2];
            REG_BOX_MAX_X: prdata = box_max_reg[0];
            REG_BOX_MAX_Y: prdata = box_max_reg[1];
            REG_BOX_MAX_Z: prdata = box_max_reg[2];
            default:       prdata = '0;
        endcase
    end

    assign box_min = box_min_reg;
    assign box_max = box_max_reg;
endmodule

// ===== design/rbs_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
// Depends on rbs_pkg for widths; advances on en.
module rbs_divider (
    input  logic                      clk,
    input  logic                      en,
    input  logic [rbs_pkg::NUM_W-1:0] num,
    input  logic [rbs_pkg::DEN_W-1:0] den,
    output logic [rbs_pkg::NUM_W-1:0] quo
);
    import rbs_pkg::*;

    logic [REM_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] nq_reg  [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];

    genvar k;
    generate
        for (k = 0; k < NUM_W; k++)
        begin : g_stage
            logic [REM_W-1:0] rem_prev;
            logic [NUM_W-1:0] nq_prev;
            logic [DEN_W-1:0] den_prev;
            logic [REM_W:0]   trial;
            logic [REM_W:0]   diff;
            logic             ge;

            if (k == 0)
            begin : g_first
                assign rem_prev = '0;
                assign nq_prev  = num;
                assign den_prev = den;
            end
            else
            begin : g_rest
                assign rem_prev = rem_reg[k-1];
                assign nq_prev  = nq_reg[k-1];
                assign den_prev = den_reg[k-1];
            end

            // Bring down the next numerator bit, subtract if it fits.
            assign trial = {rem_prev, nq_prev[NUM_W-1]};
            assign diff  = trial - {1'b0, den_prev};
            assign ge    = (trial >= {1'b0, den_prev});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
                    nq_reg[k]  <= {nq_prev[NUM_W-2:0], ge};
                    den_reg[k] <= den_prev;
                end
            end
        end
    endgenerate

    assign quo = nq_reg[NUM_W-1];
endmodule

// ===== design/rbs_axis_merge.sv =====
// One narrowing stage: clips the ray interval against the slab of the lowest axis
// in the beat, then shifts the remaining axes down. Depends on rbs_pkg.
module rbs_axis_merge (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  rbs_pkg::merge_t in_beat,
    output logic            out_valid,
    output rbs_pkg::merge_t out_beat
);
    import rbs_pkg::*;

    logic   valid_reg;
    merge_t beat_reg;
    merge_t beat_next;
    axis_t  a;

    always_comb
    begin
        a         = in_beat.ax[0];
        beat_next = in_beat;
        if (in_beat.alive)
        begin
            if (a.dzero)
            begin
                if (!a.in_slab)
                    beat_next.alive = 1'b0;
            end
            else
            begin
                if (a.t_entry > in_beat.lo)
                    beat_next.lo = a.t_entry;
                if (a.t_exit < in_beat.hi)
                    beat_next.hi = a.t_exit;
            end
            if (beat_next.hi <= beat_next.lo)
                beat_next.alive = 1'b0;
        end
        // advance the next axis into place
        beat_next.ax[0] = in_beat.ax[1];
        beat_next.ax[1] = in_beat.ax[2];
        beat_next.ax[2] = in_beat.ax[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            beat_reg <= beat_next;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;
endmodule

// ===== design/ray_box_slab_test.sv =====
// Top level of the ray versus axis-aligned box slab test.
// Depends on rbs_pkg, rbs_ray_if, rbs_hit_if, rbs_cfg_regs, rbs_divider, rbs_axis_merge.

// Ray/box slab test. One ray (origin, direction, interval [t_start, t_end], all signed
// Q16.16) is accepted per clock unless a stalled result holds the pipe, and each yields
// one hit bit after one input stage that forms plane-minus-origin differences and
// magnitudes, 49 stages of six parallel bit-per-stage dividers (the divider depth, one
// stage per quotient bit of the 49-bit scaled difference, sets the latency), one
// saturate/order stage and three narrowing stages, one per axis, whose last register is
// the output register. The whole pipe advances as one while the output is empty or being
// taken; a stalled result holds the pipe and drops ray.ready, and nothing is lost or
// repeated. The box corners sit in six 32-bit registers at byte addresses 0x00..0x14
// (min x, y, z, then max x, y, z); write them only while no ray is in flight.
module ray_box_slab_test (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rbs_pkg::ADDR_W-1:0] paddr,
    input  logic [rbs_pkg::DATA_W-1:0] pwdata,
    output logic [rbs_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    rbs_ray_if.sink                    ray,
    rbs_hit_if.source                  res
);
    import rbs_pkg::*;

    // Saturate a magnitude quotient with its sign to the 32-bit range.
    function automatic fix_t sat_q(input logic [NUM_W-1:0] q, input logic neg);
        logic              big;
        logic [DATA_W-1:0] low;
        big = |q[NUM_W-1:DATA_W-1];
        low = q[DATA_W-1:0];
        if (neg)
            sat_q = big ? FIX_MIN : fix_t'(-low);
        else
            sat_q = big ? FIX_MAX : fix_t'(low);
    endfunction

    fix_t [2:0] box_min;
    fix_t [2:0] box_max;

    rbs_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .box_min (box_min),
        .box_max (box_max)
    );

    // Global advance: move everything while the output register is free or drained.
    logic en;
    logic out_valid;
    assign en        = !out_valid || res.ready;
    assign ray.ready = en;

    // ---------------------------------------------------------------- input stage
    fix_t [2:0] org;
    fix_t [2:0] dir;
    assign org = {ray.origin_z, ray.origin_y, ray.origin_x};
    assign dir = {ray.dir_z, ray.dir_y, ray.dir_x};

    logic [2:0][NUM_W-1:0] num_min_next, num_max_next;
    logic [2:0][DEN_W-1:0] den_next;
    meta_t                 meta_next;

    always_comb
    begin
        logic signed [DIFF_W-1:0] dmin;
        logic signed [DIFF_W-1:0] dmax;
        logic        [DIFF_W-1:0] mmin;
        logic        [DIFF_W-1:0] mmax;
        meta_next.lo = ray.t_start;
        meta_next.hi = ray.t_end;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            // Plane minus origin is exact at 33 bits.
            dmin = {box_min[a][DATA_W-1], box_min[a]} - {org[a][DATA_W-1], org[a]};
            dmax = {box_max[a][DATA_W-1], box_max[a]} - {org[a][DATA_W-1], org[a]};
            mmin = dmin[DIFF_W-1] ? DIFF_W'(-dmin) : DIFF_W'(dmin);
            mmax = dmax[DIFF_W-1] ? DIFF_W'(-dmax) : DIFF_W'(dmax);
            num_min_next[a] = {mmin, {FRAC_BITS{1'b0}}};
            num_max_next[a] = {mmax, {FRAC_BITS{1'b0}}};
            den_next[a]     = dir[a][DATA_W-1] ? DEN_W'(-dir[a]) : DEN_W'(dir[a]);
            meta_next.ax[a].dzero    = (dir[a] == '0);
            meta_next.ax[a].dneg     = dir[a][DATA_W-1];
            meta_next.ax[a].in_slab  = (org[a] >= box_min[a]) && (org[a] <= box_max[a]);
            meta_next.ax[a].qneg_min = dmin[DIFF_W-1] ^ dir[a][DATA_W-1];
            meta_next.ax[a].qneg_max = dmax[DIFF_W-1] ^ dir[a][DATA_W-1];
        end
    end

    logic                  pre_valid_reg;
    logic [2:0][NUM_W-1:0] num_min_reg, num_max_reg;
    logic [2:0][DEN_W-1:0] den_reg;
    meta_t                 pre_meta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_valid_reg <= 1'b0;
        else if (en)
            pre_valid_reg <= ray.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_min_reg  <= num_min_next;
            num_max_reg  <= num_max_next;
            den_reg      <= den_next;
            pre_meta_reg <= meta_next;
        end
    end

    // ---------------------------------------------------------------- divider stages
    logic [2:0][NUM_W-1:0] quo_min, quo_max;

    genvar g;
    generate
        for (g = 0; g < NUM_AXES; g++)
        begin : g_axis
            rbs_divider u_div_min (
                .clk (clk),
                .en  (en),
                .num (num_min_reg[g]),
                .den (den_reg[g]),
                .quo (quo_min[g])
            );
            rbs_divider u_div_max (
                .clk (clk),
                .en  (en),
                .num (num_max_reg[g]),
                .den (den_reg[g]),
                .quo (quo_max[g])
            );
        end
    endgenerate

    // Side data and valid bits ride along with the divider stages.
    logic  div_valid_reg [NUM_W];
    meta_t div_meta_reg  [NUM_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_W; k++)
                div_valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            div_valid_reg[0] <= pre_valid_reg;
            for (int k = 1; k < NUM_W; k++)
                div_valid_reg[k] <= div_valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_meta_reg[0] <= pre_meta_reg;
            for (int k = 1; k < NUM_W; k++)
                div_meta_reg[k] <= div_meta_reg[k-1];
        end
    end

    // ---------------------------------------------------------------- saturate / order
    meta_t  dm;
    merge_t sat_next;
    assign dm = div_meta_reg[NUM_W-1];

    always_comb
    begin
        fix_t t_min;
        fix_t t_max;
        sat_next.alive = 1'b1;
        sat_next.lo    = dm.lo;
        sat_next.hi    = dm.hi;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            t_min = sat_q(quo_min[a], dm.ax[a].qneg_min);
            t_max = sat_q(quo_max[a], dm.ax[a].qneg_max);
            // Negative direction enters through the max plane.
            sat_next.ax[a].t_entry = dm.ax[a].dneg ? t_max : t_min;
            sat_next.ax[a].t_exit  = dm.ax[a].dneg ? t_min : t_max;
            sat_next.ax[a].dzero   = dm.ax[a].dzero;
            sat_next.ax[a].in_slab = dm.ax[a].in_slab;
        end
    end

    logic   sat_valid_reg;
    merge_t sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sat_valid_reg <= 1'b0;
        else if (en)
            sat_valid_reg <= div_valid_reg[NUM_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sat_reg <= sat_next;
    end

    // ---------------------------------------------------------------- narrowing x, y, z
    logic   mx_valid, my_valid;
    merge_t mx_beat, my_beat, mz_beat;

    rbs_axis_merge u_merge_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sat_valid_reg),
        .in_beat   (sat_reg),
        .out_valid (mx_valid),
        .out_beat  (mx_beat)
    );

    rbs_axis_merge u_merge_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mx_valid),
        .in_beat   (mx_beat),
        .out_valid (my_valid),
        .out_beat  (my_beat)
    );

    // Last narrowing register doubles as the output register.
    rbs_axis_merge u_merge_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (my_valid),
        .in_beat   (my_beat),
        .out_valid (out_valid),
        .out_beat  (mz_beat)
    );

    assign res.valid = out_valid;
    assign res.hit   = mz_beat.alive;

    // ---------------------------------------------------------------- assertions
    a_stall_only_on_output: assert property (@(posedge clk) disable iff (!rst_n)
        !ray.ready |-> (res.valid && !res.ready))
        else $error("input stalled without a blocked result");

    a_hit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.hit) |-> (mz_beat.hi > mz_beat.lo))
        else $error("hit reported with an empty interval");

    a_pre_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        (en && pre_valid_reg) |=> div_valid_reg[0])
        else $error("beat lost entering the divider");

    a_div_to_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (en && div_valid_reg[NUM_W-1]) |=> sat_valid_reg)
        else $error("beat lost leaving the divider");
endmodule

// ===== bench/rbs_slab_checker.sv =====
// Checker for the ray/box slab test: watches the ray and hit channels,
// predicts the hit bit for every accepted ray and compares it with the result.
// Depends on rbs_pkg, rbs_ray_if and rbs_hit_if.
`timescale 1ns / 100ps

module rbs_slab_checker (
    input  logic         clk,
    input  logic         rst_n,
    rbs_ray_if           ray,
    rbs_hit_if           res,
    input  rbs_pkg::fix_t box_min [3],
    input  rbs_pkg::fix_t box_max [3],
    output int           fail_count,
    output int           pending_hits
);
    import rbs_pkg::*;

    bit hit_queue[$];

    function automatic fix_t plane_crossing(fix_t plane, fix_t org, fix_t dir);
        longint diff;
        longint quot;
        diff = longint'(plane) - longint'(org);
        quot = (diff * (longint'(1) << FRAC_BITS)) / longint'(dir);
        if (quot > longint'(FIX_MAX))
            quot = longint'(FIX_MAX);
        if (quot < longint'(FIX_MIN))
            quot = longint'(FIX_MIN);
        return fix_t'(quot);
    endfunction

    function automatic bit predict_hit(fix_t org[3], fix_t dir[3], fix_t ts, fix_t te);
        fix_t lo;
        fix_t hi;
        fix_t t_near;
        fix_t t_far;
        fix_t tmp;
        lo = ts;
        hi = te;
        for (int a = 0; a < 3; a++)
        begin
            if (dir[a] == 0)
            begin
                if (org[a] < box_min[a] || org[a] > box_max[a])
                    return 1'b0;
            end
            else
            begin
                t_near = plane_crossing(box_min[a], org[a], dir[a]);
                t_far  = plane_crossing(box_max[a], org[a], dir[a]);
                if (dir[a] < 0)
                begin
                    tmp = t_near;
                    t_near = t_far;
                    t_far = tmp;
                end
                if (t_near > lo)
                    lo = t_near;
                if (t_far < hi)
                    hi = t_far;
            end
            if (hi <= lo)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
    end

    assign pending_hits = hit_queue.size();

    always @(posedge clk)
    begin
        fix_t org[3];
        fix_t dir[3];
        bit want;
        if (rst_n)
        begin
            if (ray.valid && ray.ready)
            begin
                org = '{ray.origin_x, ray.origin_y, ray.origin_z};
                dir = '{ray.dir_x, ray.dir_y, ray.dir_z};
                hit_queue.push_back(predict_hit(org, dir, ray.t_start, ray.t_end));
            end
            if (res.valid && res.ready)
            begin
                if (hit_queue.size() == 0)
                    report_mismatch("hit beat with no ray outstanding");
                else
                begin
                    want = hit_queue.pop_front();
                    if (res.hit !== want)
                        report_mismatch($sformatf("hit %b, expected %b", res.hit, want));
                end
            end
        end
    end
endmodule

// ===== bench/tb_ray_box_slab_test.sv =====
// Testbench top for the ray/box slab test: clock, reset, APB box setup,
// bursty ray stimulus, stalling receiver and the final verdict.
// Depends on rbs_pkg, rbs_ray_if, rbs_hit_if, rbs_slab_checker and the design.
`timescale 1ns / 100ps

module tb_ray_box_slab_test;
    import rbs_pkg::*;

    localparam int PIPE_DEPTH  = 54;
    localparam int RANDOM_RAYS = 650;
    localparam int CYCLE_LIMIT = 400000;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    fix_t              box_min [3];
    fix_t              box_max [3];
    int                fail_count;
    int                pending_hits;
    int                cycle_count;
    bit                stall_mode;

    rbs_ray_if ray ();
    rbs_hit_if res ();

    ray_box_slab_test uut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .ray(ray.sink), .res(res.source)
    );

    rbs_slab_checker u_checker (
        .clk(clk), .rst_n(rst_n), .ray(ray), .res(res),
        .box_min(box_min), .box_max(box_max),
        .fail_count(fail_count), .pending_hits(pending_hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Abort a hung run.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("ray_box_slab_test regression: fail");
                $finish;
            end
        end
    end

    // Receiver: stall on its own pattern; mode flips between free-running and choppy.
    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 99) == 0)
                stall_mode <= ~stall_mode;
            res.ready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
        end
    end

    // Write one box register through a setup and an access phase.
    task automatic write_box(reg_idx_t idx, fix_t value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // Mirror for the checker; the register is in place from this edge on.
        if (idx <= REG_BOX_MIN_Z)
            box_min[int'(idx)] = value;
        else
            box_max[int'(idx) - 3] = value;
    endtask

    task automatic load_box(fix_t mn[3], fix_t mx[3]);
        write_box(REG_BOX_MIN_X, mn[0]);
        write_box(REG_BOX_MIN_Y, mn[1]);
        write_box(REG_BOX_MIN_Z, mn[2]);
        write_box(REG_BOX_MAX_X, mx[0]);
        write_box(REG_BOX_MAX_Y, mx[1]);
        write_box(REG_BOX_MAX_Z, mx[2]);
    endtask

    // Drain every hit, then let the pipe settle before touching registers.
    task automatic drain_pipe();
        while (pending_hits != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    // Send one ray beat and hold it until accepted.
    task automatic send_ray(fix_t o[3], fix_t d[3], fix_t ts, fix_t te);
        ray.valid    <= 1'b1;
        ray.origin_x <= o[0];
        ray.origin_y <= o[1];
        ray.origin_z <= o[2];
        ray.dir_x    <= d[0];
        ray.dir_y    <= d[1];
        ray.dir_z    <= d[2];
        ray.t_start  <= ts;
        ray.t_end    <= te;
        do
            @(posedge clk);
        while (!ray.ready);
    endtask

    task automatic idle_ray(int cycles);
        ray.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Mostly small Q16.16 values near the box, sometimes the full range.
    function automatic fix_t rand_coord();
        case ($urandom_range(0, 9))
            0, 1:    return fix_t'($urandom);
            2:       return $urandom_range(0, 1) ? FIX_MAX : FIX_MIN;
            3:       return 0;
            default: return fix_t'($signed($urandom_range(0, 32'h000C_0000)) - 32'sh0006_0000);
        endcase
    endfunction

    function automatic fix_t rand_dir();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return fix_t'($urandom);
            2:       return fix_t'($signed($urandom_range(0, 8)) - 4);
            default: return fix_t'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
        endcase
    endfunction

    // Random ray, mostly aimed at the box center with a forward interval.
    task automatic random_ray();
        fix_t o[3];
        fix_t d[3];
        fix_t ts;
        fix_t te;
        for (int a = 0; a < 3; a++)
        begin
            o[a] = rand_coord();
            d[a] = rand_dir();
            if ($urandom_range(0, 2) != 0)
                d[a] = fix_t'((longint'(box_min[a]) + longint'(box_max[a])) / 2
                              - longint'(o[a])) >>> 2;
        end
        case ($urandom_range(0, 5))
            0:       begin ts = fix_t'($urandom); te = fix_t'($urandom); end
            1:       begin ts = FIX_MIN; te = FIX_MAX; end
            default: begin ts = 0; te = fix_t'($urandom_range(1, 32'h0010_0000)); end
        endcase
        send_ray(o, d, ts, te);
    endtask

    task automatic random_phase(int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 30);
            for (int k = 0; k < burst && sent < count; k++)
            begin
                random_ray();
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_ray($urandom_range(1, 6));
        end
        idle_ray(1);
    endtask

    initial
    begin
        fix_t mn[3];
        fix_t mx[3];
        fix_t u[3];
        fix_t z[3];
        fix_t ng[3];
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        ray.valid = 1'b0;
        ray.origin_x = '0; ray.origin_y = '0; ray.origin_z = '0;
        ray.dir_x = '0; ray.dir_y = '0; ray.dir_z = '0;
        ray.t_start = '0; ray.t_end = '0;
        stall_mode = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            box_min[a] = 0;
            box_max[a] = 0;
        end
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: unit box at [-1, 1]^3.
        mn = '{-32'sh10000, -32'sh10000, -32'sh10000};
        mx = '{32'sh10000, 32'sh10000, 32'sh10000};
        load_box(mn, mx);
        u  = '{32'sh10000, 32'sh10000, 32'sh10000};
        z  = '{0, 0, 0};
        ng = '{-32'sh10000, -32'sh10000, -32'sh10000};
        send_ray('{-32'sh30000, 0, 0}, '{32'sh10000, 0, 0}, 0, 32'sh100000);   // hit along x
        send_ray('{32'sh30000, 0, 0}, '{-32'sh10000, 0, 0}, 0, 32'sh100000);   // negative dir
        send_ray('{32'sh30000, 0, 0}, '{32'sh10000, 0, 0}, 0, 32'sh100000);    // pointing away
        send_ray(z, z, 0, 32'sh10000);                                          // zero dir in slab
        send_ray('{32'sh10000, 32'sh10000, 32'sh10000}, z, 0, 32'sh10000);     // on face, inclusive
        send_ray('{32'sh10001, 0, 0}, z, 0, 32'sh10000);                        // zero dir outside
        send_ray(z, u, 32'sh10000, 32'sh10000);                                 // empty interval
        send_ray(z, u, 32'sh20000, 32'sh10000);                                 // inverted interval
        send_ray('{FIX_MIN, FIX_MIN, FIX_MIN}, '{1, 1, 1}, FIX_MIN, FIX_MAX);   // saturate high
        send_ray('{FIX_MAX, FIX_MAX, FIX_MAX}, '{-1, -1, -1}, FIX_MIN, FIX_MAX);
        send_ray('{FIX_MAX, FIX_MIN, FIX_MAX}, '{FIX_MIN, FIX_MAX, FIX_MIN}, FIX_MIN, FIX_MAX);
        send_ray(z, '{FIX_MIN, FIX_MIN, FIX_MIN}, FIX_MIN, FIX_MAX);
        send_ray('{32'sh20000, 0, 0}, '{-32'sh10000, 0, 0}, 0, 32'sh10000);    // t_end == entry
        send_ray(z, ng, FIX_MIN, FIX_MAX);
        send_ray('{-1, -1, -1}, '{32'hFFFF_FFFF, 32'h7FFF, 32'h8000}, 0, -1);
        idle_ray(1);

        // Pause the sender until the pipe is empty.
        drain_pipe();

        // Inverted box: zero dir must always miss, nonzero ordered by sign only.
        load_box('{32'sh10000, 32'sh10000, 32'sh10000}, '{-32'sh10000, -32'sh10000, -32'sh10000});
        send_ray(z, z, FIX_MIN, FIX_MAX);
        send_ray('{-32'sh30000, 0, 0}, u, FIX_MIN, FIX_MAX);
        send_ray('{32'sh30000, 0, 0}, ng, FIX_MIN, FIX_MAX);
        idle_ray(1);
        drain_pipe();

        // Random phases over several boxes, extremes among them.
        load_box('{-32'sh10000, -32'sh20000, -32'sh8000}, '{32'sh30000, 32'sh10000, 32'sh18000});
        random_phase(RANDOM_RAYS / 4);
        drain_pipe();
        load_box('{FIX_MIN, FIX_MIN, FIX_MIN}, '{FIX_MAX, FIX_MAX, FIX_MAX});
        random_phase(RANDOM_RAYS / 4);
        drain_pipe();
        load_box('{FIX_MAX, FIX_MIN, 0}, '{FIX_MIN, FIX_MAX, 0});
        random_phase(RANDOM_RAYS / 8);
        drain_pipe();
        for (int a = 0; a < 3; a++)
        begin
            mn[a] = fix_t'($urandom);
            mx[a] = fix_t'($urandom);
            if ($urandom_range(0, 3) != 0 && mn[a] > mx[a])
            begin
                u[a] = mn[a]; mn[a] = mx[a]; mx[a] = u[a];
            end
        end
        load_box(mn, mx);
        random_phase(RANDOM_RAYS / 8);
        drain_pipe();
        load_box('{-32'sh8000, -32'sh8000, -32'sh8000}, '{32'sh8000, 32'sh8000, 32'sh8000});
        random_phase(RANDOM_RAYS / 4);

        drain_pipe();
        if (fail_count == 0)
            $display("ray_box_slab_test regression: pass");
        else
            $display("ray_box_slab_test regression: fail");
        $finish;
    end
endmodule
